@@ hw/rtl/lsrf_pkg.sv @@
// Package for the logic/shift/rotate/flags unit: operation codes, width codes,
// condition codes and the flag and result types. No dependencies.
`timescale 1ns / 1ps

package lsrf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int REQ_W          = 4;
    localparam int WCODE_W        = 2;
    localparam int CC_W           = 4;
    localparam int CNT_W          = 5;

    typedef enum logic [REQ_W-1:0] {
        OP_TEST  = 4'd0,
        OP_AND   = 4'd1,
        OP_XOR   = 4'd2,
        OP_OR    = 4'd3,
        OP_SAR   = 4'd4,
        OP_SHL   = 4'd5,
        OP_SHR   = 4'd6,
        OP_SETCC = 4'd7,
        OP_NOT   = 4'd8,
        OP_ROR   = 4'd9,
        OP_ROL   = 4'd10,
        OP_LDFL  = 4'd11
    } t_op;

    localparam logic [WCODE_W-1:0] WC_8  = 2'd0;
    localparam logic [WCODE_W-1:0] WC_16 = 2'd1;

    // condition code bits [3:1]
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_E  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic of;
        logic sf;
        logic zf;
        logic cf;
    } t_flags;

    typedef struct packed {
        logic   write_back;
        logic   bad_condition;
        t_flags flags;
    } t_exec_status;

endpackage

@@ hw/rtl/logic_shift_rotate_flags_unit.sv @@
// Top level of the x86 logic/shift/rotate unit with CF/ZF/SF/OF flag state.
// An item passes from the input registers through the combinational execute
// stage into the result registers. Throughput: one item per cycle while the output
// is not stalled, set by the single execute pass between input and result registers.
// Flags update as an item leaves the execute stage, so the next item sees them.
// Synchronous active-low reset clears valids and flags to zero.
// Depends on lsrf_pkg and lsrf_exec.
`timescale 1ns / 1ps

module logic_shift_rotate_flags_unit
    import lsrf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [WCODE_W-1:0]    i_width_code,
    input  logic [DATA_WIDTH-1:0] i_dest_value,
    input  logic [DATA_WIDTH-1:0] i_src_value,
    input  logic [CC_W-1:0]       i_cond_code,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DATA_WIDTH-1:0] o_result,
    output logic                  o_write_back,
    output logic                  o_carry_flag,
    output logic                  o_zero_flag,
    output logic                  o_sign_flag,
    output logic                  o_overflow_flag,
    output logic                  o_bad_condition
);

    logic                  r_in_valid;
    logic [REQ_W-1:0]      r_req_type;
    logic [WCODE_W-1:0]    r_width_code;
    logic [DATA_WIDTH-1:0] r_dest_value;
    logic [DATA_WIDTH-1:0] r_src_value;
    logic [CC_W-1:0]       r_cond_code;

    t_flags                r_flags;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_result;
    t_exec_status          r_status;

    logic [DATA_WIDTH-1:0] n_result;
    t_exec_status          n_status;
    t_flags                n_flags;
    logic                  res_zero;
    logic                  res_sign;
    logic                  out_free;
    logic                  advance;
    logic                  in_xfer;

    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || out_free;
    assign in_xfer    = i_in_valid && o_in_ready;

    lsrf_exec #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_exec (
        .i_req_type  (r_req_type),
        .i_width_code(r_width_code),
        .i_dest_value(r_dest_value),
        .i_src_value (r_src_value),
        .i_cond_code (r_cond_code),
        .i_flags     (r_flags),
        .o_result    (n_result),
        .o_status    (n_status)
    );

    assign res_zero = (n_result == '0);

    always_comb begin
        case (r_width_code)
            WC_8:    res_sign = n_result[7];
            WC_16:   res_sign = n_result[15];
            default: res_sign = n_result[DATA_WIDTH-1];
        endcase
    end

    // result-dependent flags; rotates touch CF only for a nonzero count
    always_comb begin
        n_flags = n_status.flags;
        case (t_op'(r_req_type)) inside
            OP_TEST, OP_AND, OP_XOR, OP_OR: begin
                n_flags.cf = 1'b0;
                n_flags.of = 1'b0;
                n_flags.zf = res_zero;
                n_flags.sf = res_sign;
            end
            OP_ROL: begin
                if (r_src_value[CNT_W-1:0] != '0) begin
                    n_flags.cf = n_result[0];
                end
            end
            OP_ROR: begin
                if (r_src_value[CNT_W-1:0] != '0) begin
                    n_flags.cf = res_sign;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_flags     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_flags     <= n_flags;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req_type   <= i_req_type;
            r_width_code <= i_width_code;
            r_dest_value <= i_dest_value;
            r_src_value  <= i_src_value;
            r_cond_code  <= i_cond_code;
        end
        if (advance) begin
            r_result               <= n_result;
            r_status.write_back    <= n_status.write_back;
            r_status.bad_condition <= n_status.bad_condition;
            r_status.flags         <= n_flags;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result        = r_result;
    assign o_write_back    = r_status.write_back;
    assign o_bad_condition = r_status.bad_condition;
    assign o_carry_flag    = r_status.flags.cf;
    assign o_zero_flag     = r_status.flags.zf;
    assign o_sign_flag     = r_status.flags.sf;
    assign o_overflow_flag = r_status.flags.of;

endmodule

@@ hw/rtl/lsrf_exec.sv @@
// Combinational execute stage: logic ops, shifts, rotates, setcc, flag load.
// Depends on lsrf_pkg.
`timescale 1ns / 1ps

module lsrf_exec
    import lsrf_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [WCODE_W-1:0]    i_width_code,
    input  logic [DATA_WIDTH-1:0] i_dest_value,
    input  logic [DATA_WIDTH-1:0] i_src_value,
    input  logic [CC_W-1:0]       i_cond_code,
    input  t_flags                i_flags,
    output logic [DATA_WIDTH-1:0] o_result,
    output t_exec_status          o_status
);

    logic [DATA_WIDTH-1:0]   mask;
    logic [DATA_WIDTH-1:0]   d;
    logic [DATA_WIDTH-1:0]   rep;
    logic [DATA_WIDTH-1:0]   sext;
    logic [2*DATA_WIDTH-1:0] dbl;
    logic [2*DATA_WIDTH-1:0] rol_full;
    logic [2*DATA_WIDTH-1:0] ror_full;
    logic [DATA_WIDTH-1:0]   sar_full;
    logic [CNT_W-1:0]        cnt;
    logic                    cond;

    assign cnt = i_src_value[CNT_W-1:0];

    always_comb begin
        case (i_width_code)
            WC_8: begin
                mask = {{(DATA_WIDTH-8){1'b0}}, 8'hFF};
                d    = {{(DATA_WIDTH-8){1'b0}}, i_dest_value[7:0]};
                rep  = {(DATA_WIDTH/8){i_dest_value[7:0]}};
                sext = {{(DATA_WIDTH-8){i_dest_value[7]}}, i_dest_value[7:0]};
            end
            WC_16: begin
                mask = {{(DATA_WIDTH-16){1'b0}}, 16'hFFFF};
                d    = {{(DATA_WIDTH-16){1'b0}}, i_dest_value[15:0]};
                rep  = {(DATA_WIDTH/16){i_dest_value[15:0]}};
                sext = {{(DATA_WIDTH-16){i_dest_value[15]}}, i_dest_value[15:0]};
            end
            default: begin
                mask = '1;
                d    = i_dest_value;
                rep  = i_dest_value;
                sext = i_dest_value;
            end
        endcase
    end

    // replicated operand: a full-width rotate rotates every lane the same way
    assign dbl      = {rep, rep};
    assign rol_full = dbl << cnt;
    assign ror_full = dbl >> cnt;
    assign sar_full = $unsigned($signed(sext) >>> cnt);

    always_comb begin
        unique case (i_cond_code[3:1])
            CC_O:    cond = i_flags.of;
            CC_B:    cond = i_flags.cf;
            CC_E:    cond = i_flags.zf;
            CC_BE:   cond = i_flags.cf | i_flags.zf;
            CC_S:    cond = i_flags.sf;
            CC_L:    cond = i_flags.sf ^ i_flags.of;
            CC_LE:   cond = i_flags.zf | (i_flags.sf ^ i_flags.of);
            default: cond = 1'b0;
        endcase
        cond = cond ^ i_cond_code[0];
    end

    always_comb begin
        o_result               = '0;
        o_status.write_back    = 1'b0;
        o_status.bad_condition = 1'b0;
        o_status.flags         = i_flags;
        unique case (t_op'(i_req_type))
            OP_TEST: o_result = d & i_src_value & mask;
            OP_AND: begin
                o_result            = d & i_src_value & mask;
                o_status.write_back = 1'b1;
            end
            OP_XOR: begin
                o_result            = (d ^ i_src_value) & mask;
                o_status.write_back = 1'b1;
            end
            OP_OR: begin
                o_result            = (d | i_src_value) & mask;
                o_status.write_back = 1'b1;
            end
            OP_SAR: begin
                o_result            = sar_full & mask;
                o_status.write_back = 1'b1;
            end
            OP_SHL: begin
                o_result            = (d << cnt) & mask;
                o_status.write_back = 1'b1;
            end
            OP_SHR: begin
                o_result            = (d >> cnt) & mask;
                o_status.write_back = 1'b1;
            end
            OP_SETCC: begin
                if (i_cond_code[3:1] == CC_P) begin
                    o_status.bad_condition = 1'b1;
                end else begin
                    o_result            = {{(DATA_WIDTH-1){1'b0}}, cond};
                    o_status.write_back = 1'b1;
                end
            end
            OP_NOT: begin
                o_result            = ~d & mask;
                o_status.write_back = 1'b1;
            end
            OP_ROR: begin
                o_result            = ror_full[DATA_WIDTH-1:0] & mask;
                o_status.write_back = 1'b1;
            end
            OP_ROL: begin
                o_result            = rol_full[2*DATA_WIDTH-1:DATA_WIDTH] & mask;
                o_status.write_back = 1'b1;
            end
            OP_LDFL: o_status.flags = t_flags'(i_src_value[3:0]);
            default: ;
        endcase
    end

endmodule

@@ dv/tb.sv @@
// Testbench for logic_shift_rotate_flags_unit: directed and random x86 logic,
// shift, rotate, setcc and flag-load transfers, checked by a flag-tracking scoreboard.
// Depends on lsrf_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb;
    import lsrf_pkg::*;

    localparam logic [WCODE_W-1:0] WC_32   = 2'd2;
    localparam logic [WCODE_W-1:0] WC_FULL = 2'd3;
    localparam logic [REQ_W-1:0]   OP_SPARE_LO = REQ_W'(OP_LDFL + 1);
    localparam logic [REQ_W-1:0]   OP_SPARE_HI = '1;
    localparam int                 RANDOM_ITEMS = 880;

    typedef struct {
        logic [DATA_WIDTH_DEF-1:0] result;
        logic                      write_back;
        t_flags                    flags;
        logic                      bad_condition;
    } t_exec_outcome;

    class lsrf_scoreboard;
        t_flags        arch_flags;
        t_exec_outcome expected_results[$];
        int unsigned   errors;

        function new();
            arch_flags = '0;
            errors     = 0;
        endfunction

        function bit condition_holds(logic [CC_W-1:0] cc);
            bit r;
            case (cc[3:1])
                CC_O:    r = arch_flags.of;
                CC_B:    r = arch_flags.cf;
                CC_E:    r = arch_flags.zf;
                CC_BE:   r = arch_flags.cf | arch_flags.zf;
                CC_S:    r = arch_flags.sf;
                CC_L:    r = arch_flags.sf ^ arch_flags.of;
                CC_LE:   r = arch_flags.zf | (arch_flags.sf ^ arch_flags.of);
                default: r = 1'b0;
            endcase
            return cc[0] ? !r : r;
        endfunction

        function void set_logic_flags(logic [31:0] v, int unsigned w);
            arch_flags    = '0;
            arch_flags.zf = (v == 0);
            arch_flags.sf = v[w-1];
        endfunction

        function void predict_instruction(logic [REQ_W-1:0] op, logic [WCODE_W-1:0] wc,
                                          logic [31:0] dv, logic [31:0] sv,
                                          logic [CC_W-1:0] cc);
            int unsigned        w;
            int unsigned        rot;
            logic [31:0]        m;
            logic [31:0]        d;
            logic [31:0]        res;
            logic signed [31:0] shifted;
            logic [CNT_W-1:0]   cnt;
            logic               wb;
            logic               bad;
            t_exec_outcome      e;
            w   = (wc == WC_8) ? 8 : (wc == WC_16) ? 16 : DATA_WIDTH_DEF;
            m   = (w >= 32) ? '1 : ((32'd1 << w) - 32'd1);
            d   = dv & m;
            cnt = sv[CNT_W-1:0];
            res = '0;
            wb  = 1'b0;
            bad = 1'b0;
            case (op)
                OP_TEST, OP_AND: begin
                    res = d & sv;
                    wb  = (op == OP_AND);
                    set_logic_flags(res, w);
                end
                OP_XOR: begin
                    res = (d ^ sv) & m;
                    wb  = 1'b1;
                    set_logic_flags(res, w);
                end
                OP_OR: begin
                    res = (d | sv) & m;
                    wb  = 1'b1;
                    set_logic_flags(res, w);
                end
                OP_SAR: begin
                    shifted = d[w-1] ? (d | ~m) : d;
                    shifted = shifted >>> cnt;
                    res     = shifted & m;
                    wb      = 1'b1;
                end
                OP_SHL: begin
                    res = (d << cnt) & m;
                    wb  = 1'b1;
                end
                OP_SHR: begin
                    res = d >> cnt;
                    wb  = 1'b1;
                end
                OP_SETCC: begin
                    if (cc[3:1] == CC_P) begin
                        bad = 1'b1;
                    end else begin
                        res = {31'd0, condition_holds(cc)};
                        wb  = 1'b1;
                    end
                end
                OP_NOT: begin
                    res = ~d & m;
                    wb  = 1'b1;
                end
                OP_ROR, OP_ROL: begin
                    rot = cnt % w;
                    res = d;
                    if (rot != 0) begin
                        if (op == OP_ROL)
                            res = ((d << rot) | (d >> (w - rot))) & m;
                        else
                            res = ((d >> rot) | (d << (w - rot))) & m;
                    end
                    if (cnt != 0)
                        arch_flags.cf = (op == OP_ROL) ? res[0] : res[w-1];
                    wb = 1'b1;
                end
                OP_LDFL: arch_flags = t_flags'(sv[3:0]);
                default: ;
            endcase
            e.result        = res;
            e.write_back    = wb;
            e.flags         = arch_flags;
            e.bad_condition = bad;
            expected_results.push_back(e);
        endfunction

        function int unsigned pending_count();
            return expected_results.size();
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [31:0] res, logic wb, logic cf, logic zf,
                                   logic sf, logic of, logic bad);
            t_exec_outcome e;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, got %h", $time, res);
                return;
            end
            e = expected_results.pop_front();
            compare_field("result", e.result, res);
            compare_field("write_back", e.write_back, wb);
            compare_field("carry_flag", e.flags.cf, cf);
            compare_field("zero_flag", e.flags.zf, zf);
            compare_field("sign_flag", e.flags.sf, sf);
            compare_field("overflow_flag", e.flags.of, of);
            compare_field("bad_condition", e.bad_condition, bad);
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [REQ_W-1:0]          i_req_type;
    logic [WCODE_W-1:0]        i_width_code;
    logic [DATA_WIDTH_DEF-1:0] i_dest_value;
    logic [DATA_WIDTH_DEF-1:0] i_src_value;
    logic [CC_W-1:0]           i_cond_code;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [DATA_WIDTH_DEF-1:0] o_result;
    logic                      o_write_back;
    logic                      o_carry_flag;
    logic                      o_zero_flag;
    logic                      o_sign_flag;
    logic                      o_overflow_flag;
    logic                      o_bad_condition;
    logic                      quiet = 1'b0;

    lsrf_scoreboard sb = new();

    logic_shift_rotate_flags_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_width_code    (i_width_code),
        .i_dest_value    (i_dest_value),
        .i_src_value     (i_src_value),
        .i_cond_code     (i_cond_code),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result        (o_result),
        .o_write_back    (o_write_back),
        .o_carry_flag    (o_carry_flag),
        .o_zero_flag     (o_zero_flag),
        .o_sign_flag     (o_sign_flag),
        .o_overflow_flag (o_overflow_flag),
        .o_bad_condition (o_bad_condition)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.predict_instruction(i_req_type, i_width_code, i_dest_value, i_src_value,
                                       i_cond_code);
            if (o_out_valid && i_out_ready)
                sb.check_result(o_result, o_write_back, o_carry_flag, o_zero_flag,
                                o_sign_flag, o_overflow_flag, o_bad_condition);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // stretches where neither side idles
    initial begin
        forever begin
            repeat ($urandom_range(300, 60)) @(negedge i_clk);
            quiet = ($urandom_range(3) == 0);
        end
    end

    initial begin
        int unsigned stall;
        forever begin
            stall = quiet ? 0 : pick_gap();
            if (stall != 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
    end

    task automatic send_item(input logic [REQ_W-1:0] op, input logic [WCODE_W-1:0] wc,
                             input logic [31:0] dv, input logic [31:0] sv,
                             input logic [CC_W-1:0] cc);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_req_type   <= op;
        i_width_code <= wc;
        i_dest_value <= dv;
        i_src_value  <= sv;
        i_cond_code  <= cc;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_sender(input int unsigned n);
        if (n != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        logic [REQ_W-1:0]   op;
        logic [WCODE_W-1:0] wc;
        logic [31:0]        dv;
        logic [31:0]        sv;
        int unsigned        r;
        r  = $urandom_range(99);
        op = (r < 5) ? REQ_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO))
                     : REQ_W'($urandom_range(OP_LDFL));
        wc = WCODE_W'($urandom_range(3));
        r  = $urandom_range(9);
        dv = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        r  = $urandom_range(9);
        sv = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
        send_item(op, wc, dv, sv, CC_W'($urandom_range(15)));
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_req_type   = '0;
        i_width_code = '0;
        i_dest_value = '0;
        i_src_value  = '0;
        i_cond_code  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_TEST, WC_8, 32'hFFFF_FF80, 32'h0000_00FF, '0);
        send_item(OP_AND, WC_16, 32'h1234_F0F0, 32'h0000_0F0F, '0);
        send_item(OP_XOR, WC_32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
        send_item(OP_OR, WC_FULL, 32'h8000_0000, 32'h0000_0000, '0);
        send_item(OP_NOT, WC_8, 32'h0000_AB00, 32'h0000_0000, '0);
        send_item(OP_SAR, WC_8, 32'h0000_0080, 32'h0000_0007, '0);
        send_item(OP_SAR, WC_32, 32'h8000_0001, 32'hFFFF_FFFF, '0);
        send_item(OP_SAR, WC_16, 32'h0000_7FFF, 32'h0000_0020, '0);
        send_item(OP_SHL, WC_32, 32'hFFFF_FFFF, 32'h0000_001F, '0);
        send_item(OP_SHR, WC_16, 32'hFFFF_FFFF, 32'hFFFF_FFE4, '0);
        send_item(OP_LDFL, WC_8, 32'h0000_0000, 32'hFFFF_FFFF, '0);
        // zero count keeps CF; count equal to width still updates it
        send_item(OP_ROL, WC_8, 32'h0000_0081, 32'h0000_0000, '0);
        send_item(OP_ROR, WC_8, 32'h0000_0001, 32'h0000_0008, '0);
        send_item(OP_ROL, WC_16, 32'h0000_8001, 32'h0000_001F, '0);
        send_item(OP_ROR, WC_FULL, 32'h0000_0001, 32'h0000_0001, '0);
        send_item(OP_LDFL, WC_8, 32'hFFFF_FFFF, 32'hFFFF_FFF0, '0);
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_O, 1'b1});
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_P, 1'b0});
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_P, 1'b1});
        send_item(OP_LDFL, WC_8, 32'h0, 32'h0000_0009, '0);
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_L, 1'b0});
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_BE, 1'b1});
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_LE, 1'b0});
        send_item(OP_SPARE_HI, WC_FULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
        send_item(OP_SETCC, WC_8, 32'h0, 32'h0, {CC_S, 1'b1});

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            else
                idle_sender(quiet ? 0 : pick_gap());
            random_item();
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/lsrf_pkg.sv
hw/rtl/lsrf_exec.sv
hw/rtl/logic_shift_rotate_flags_unit.sv
dv/tb.sv
